[hw/rtl/assert_macros.svh]
// Assertion macros used by the step pulse mover.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[hw/rtl/cxy_pkg.sv]
// Shared types and constants for the CoreXY step pulse mover.
// No dependencies.
package cxy_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int STEP_COUNT_BITS_DEF = 24;

  localparam int TICK_W   = 20;
  localparam int HL_W     = 16;
  localparam int PAUSE_W  = 20;
  localparam int SCALE_W  = 8;
  localparam int LIMIT_W  = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int IN_COORD_W  = 16;
  localparam int POS_X_W     = 15;
  localparam int POS_Y_W     = 16;

  localparam logic [HL_W-1:0]    HIGH_TICKS_RST = 16'd5;
  localparam logic [HL_W-1:0]    LOW_TICKS_RST  = 16'd5;
  localparam logic [PAUSE_W-1:0] PAUSE_RST      = 20'd500000;
  localparam logic [SCALE_W-1:0] X_SCALE_RST    = 8'd1;
  localparam logic [SCALE_W-1:0] Y_SCALE_RST    = 8'd1;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST    = 15'd400;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_X,
    PH_PAUSE,
    PH_Y
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_TICKS,
    CFG_LOW_TICKS,
    CFG_PAUSE_TICKS,
    CFG_X_SCALE,
    CFG_Y_SCALE,
    CFG_Y_LIMIT
  } cfg_idx_e;

  typedef enum logic {
    ACT_TICK,
    ACT_MOVE
  } action_e;

endpackage

[hw/rtl/cxy_move_plan.sv]
// Move planner: clamps a move target and sizes both legs in drive steps.
// Depends on cxy_pkg.
module cxy_move_plan #(
  parameter int COORD_BITS      = cxy_pkg::COORD_BITS_DEF,
  parameter int STEP_COUNT_BITS = cxy_pkg::STEP_COUNT_BITS_DEF
) (
  input  logic signed [cxy_pkg::IN_COORD_W-1:0] dest_x_i,
  input  logic signed [cxy_pkg::IN_COORD_W-1:0] dest_y_i,
  input  logic signed [COORD_BITS-1:0]          pos_x_i,
  input  logic signed [COORD_BITS-1:0]          pos_y_i,
  input  logic [cxy_pkg::SCALE_W-1:0]           x_scale_i,
  input  logic [cxy_pkg::SCALE_W-1:0]           y_scale_i,
  input  logic [cxy_pkg::LIMIT_W-1:0]           y_limit_i,
  output logic signed [COORD_BITS-1:0]          pend_x_o,
  output logic signed [COORD_BITS-1:0]          pend_y_o,
  output logic [STEP_COUNT_BITS-1:0]            x_steps_o,
  output logic [STEP_COUNT_BITS-1:0]            y_steps_o,
  output logic                                  x_neg_o
);
  import cxy_pkg::*;

  localparam int EW = ((COORD_BITS > IN_COORD_W) ? COORD_BITS : IN_COORD_W) + 1;
  localparam int PW = COORD_BITS + 1 + SCALE_W;
  localparam int MW = ((PW > STEP_COUNT_BITS) ? PW : STEP_COUNT_BITS) + 1;
  localparam longint CMAX_L = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam logic signed [EW-1:0] CMAX = EW'(CMAX_L);
  localparam logic [MW-1:0] CAP = MW'({STEP_COUNT_BITS{1'b1}});

  logic signed [EW-1:0]     tx_e, ty_e, lim_e, lim, tx_c, ty_c;
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0]      dx_mag, dy_mag;
  logic [PW-1:0]            x_prod, y_prod;
  logic [MW-1:0]            x_prod_m, y_prod_m;

  assign tx_e  = EW'(dest_x_i);
  assign ty_e  = EW'(dest_y_i);
  assign lim_e = signed'(EW'(y_limit_i));
  assign lim   = (lim_e > CMAX) ? CMAX : lim_e;

  always_comb begin
    tx_c = tx_e;
    if (tx_e < 0) begin
      tx_c = '0;
    end else if (tx_e > CMAX) begin
      tx_c = CMAX;
    end
    ty_c = ty_e;
    if (ty_e > lim) begin
      ty_c = lim;
    end else if (ty_e < -lim) begin
      ty_c = -lim;
    end
  end

  assign pend_x_o = COORD_BITS'(tx_c);
  assign pend_y_o = COORD_BITS'(ty_c);

  assign dx = (COORD_BITS+1)'(pend_x_o) - (COORD_BITS+1)'(pos_x_i);
  assign dy = (COORD_BITS+1)'(pend_y_o) - (COORD_BITS+1)'(pos_y_i);
  assign dx_mag = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
  assign dy_mag = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);
  assign x_neg_o = dx[COORD_BITS];

  assign x_prod = PW'(dx_mag) * PW'(x_scale_i);
  assign y_prod = PW'(dy_mag) * PW'(y_scale_i);
  assign x_prod_m = MW'(x_prod);
  assign y_prod_m = MW'(y_prod);

  assign x_steps_o = STEP_COUNT_BITS'((x_prod_m > CAP) ? CAP : x_prod_m);
  assign y_steps_o = STEP_COUNT_BITS'((y_prod_m > CAP) ? CAP : y_prod_m);

endmodule

[hw/rtl/corexy_step_pulse_mover.sv]
// CoreXY step pulse mover: one result item per input item, registered in the cycle after accept.
// Throughput one item per cycle while the output is not stalled; a pending result sits in the
// output register while the next item is taken. The move planner (clamp, multiply) sets the path.
// Reset (rst_ni low, asynchronous) clears position and sequencer, loads register defaults and
// empties the output register. Depends on cxy_pkg, cxy_move_plan and assert_macros.svh.
module corexy_step_pulse_mover #(
  parameter int COORD_BITS      = cxy_pkg::COORD_BITS_DEF,
  parameter int STEP_COUNT_BITS = cxy_pkg::STEP_COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cxy_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cxy_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] dest_x, [31:16] dest_y
  input  logic [cxy_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] action
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] left_step, [1] right_step, [2] left_cw, [3] right_cw, [4] busy_res,
  // [5] done_res, [20:6] position_x, [36:21] position_y, [39:37] zero
  output logic [cxy_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import cxy_pkg::*;

  `include "assert_macros.svh"

  localparam int PEW = (COORD_BITS > POS_Y_W) ? COORD_BITS : POS_Y_W;

  logic [HL_W-1:0]    high_ticks_q, low_ticks_q;
  logic [PAUSE_W-1:0] pause_ticks_q;
  logic [SCALE_W-1:0] x_scale_q, y_scale_q;
  logic [LIMIT_W-1:0] y_limit_q;

  phase_e phase_q, phase_d;
  logic signed [COORD_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [COORD_BITS-1:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic [STEP_COUNT_BITS-1:0]   steps_q, steps_d, ysaved_q, ysaved_d;
  logic [TICK_W-1:0]            tick_q, tick_d;
  logic [1:0]                   dir_q, dir_d;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                         fire, is_move;
  logic signed [COORD_BITS-1:0] plan_x, plan_y;
  logic [STEP_COUNT_BITS-1:0]   plan_xs, plan_ys;
  logic                         plan_x_neg;
  logic                         go_pause, go_y, finish;
  logic [TICK_W:0]              tick_inc;
  logic [HL_W:0]                hl_sum;
  logic [HL_W+1:0]              h2l_sum;
  logic [HL_W+2:0]              period;
  logic                         ls, rs, done;
  logic signed [PEW-1:0]        px_ext, py_ext;

  assign fire    = s_axis_tvalid && s_axis_tready;
  assign is_move = (action_e'(s_axis_tuser) == ACT_MOVE);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_ticks_q  <= HIGH_TICKS_RST;
      low_ticks_q   <= LOW_TICKS_RST;
      pause_ticks_q <= PAUSE_RST;
      x_scale_q     <= X_SCALE_RST;
      y_scale_q     <= Y_SCALE_RST;
      y_limit_q     <= Y_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HIGH_TICKS:  high_ticks_q  <= cfg_data_i[HL_W-1:0];
        CFG_LOW_TICKS:   low_ticks_q   <= cfg_data_i[HL_W-1:0];
        CFG_PAUSE_TICKS: pause_ticks_q <= cfg_data_i[PAUSE_W-1:0];
        CFG_X_SCALE:     x_scale_q     <= cfg_data_i[SCALE_W-1:0];
        CFG_Y_SCALE:     y_scale_q     <= cfg_data_i[SCALE_W-1:0];
        CFG_Y_LIMIT:     y_limit_q     <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  cxy_move_plan #(
    .COORD_BITS      (COORD_BITS),
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_plan (
    .dest_x_i   (s_axis_tdata[IN_COORD_W-1:0]),
    .dest_y_i   (s_axis_tdata[2*IN_COORD_W-1:IN_COORD_W]),
    .pos_x_i    (pos_x_q),
    .pos_y_i    (pos_y_q),
    .x_scale_i  (x_scale_q),
    .y_scale_i  (y_scale_q),
    .y_limit_i  (y_limit_q),
    .pend_x_o   (plan_x),
    .pend_y_o   (plan_y),
    .x_steps_o  (plan_xs),
    .y_steps_o  (plan_ys),
    .x_neg_o    (plan_x_neg)
  );

  assign tick_inc = (TICK_W+1)'(tick_q) + 1'b1;
  assign hl_sum   = (HL_W+1)'(high_ticks_q) + (HL_W+1)'(low_ticks_q);
  assign h2l_sum  = (HL_W+2)'(hl_sum) + (HL_W+2)'(high_ticks_q);
  assign period   = (HL_W+3)'(hl_sum) << 1;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    pend_x_d = pend_x_q;
    pend_y_d = pend_y_q;
    steps_d  = steps_q;
    ysaved_d = ysaved_q;
    tick_d   = tick_q;
    dir_d    = dir_q;
    go_pause = 1'b0;
    go_y     = 1'b0;
    finish   = 1'b0;
    if (fire) begin
      if (is_move) begin
        if (phase_q == PH_IDLE) begin
          pend_x_d = plan_x;
          pend_y_d = plan_y;
          ysaved_d = plan_ys;
          tick_d   = '0;
          if (plan_xs != '0) begin
            dir_d   = plan_x_neg ? 2'b11 : 2'b00;
            steps_d = plan_xs;
            phase_d = PH_X;
          end else begin
            go_pause = 1'b1;
          end
        end
      end else begin
        case (phase_q)
          PH_X, PH_Y: begin
            if (tick_inc >= (TICK_W+1)'(period)) begin
              tick_d = '0;
              if (steps_q != '0) begin
                steps_d = steps_q - 1'b1;
              end
              if (steps_d == '0) begin
                if (phase_q == PH_X) begin
                  go_pause = 1'b1;
                end else begin
                  finish = 1'b1;
                end
              end
            end else begin
              tick_d = TICK_W'(tick_inc);
            end
          end
          PH_PAUSE: begin
            tick_d = TICK_W'(tick_inc);
            if (tick_inc >= (TICK_W+1)'(pause_ticks_q)) begin
              go_y = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    if (go_pause) begin
      phase_d = PH_PAUSE;
      tick_d  = '0;
      if (pause_ticks_q == '0) begin
        go_y = 1'b1;
      end
    end
    if (go_y) begin
      tick_d = '0;
      if (ysaved_d == '0) begin
        finish = 1'b1;
      end else begin
        steps_d  = ysaved_d;
        ysaved_d = '0;
        dir_d    = (pend_y_d > pos_y_q) ? 2'b10 : 2'b01;
        phase_d  = PH_Y;
      end
    end
    if (finish) begin
      pos_x_d = pend_x_d;
      pos_y_d = pend_y_d;
      phase_d = PH_IDLE;
      steps_d = '0;
      tick_d  = '0;
    end
  end

  // Outputs
  always_comb begin
    ls   = 1'b0;
    rs   = 1'b0;
    done = 1'b0;
    if (fire && !is_move && (phase_q == PH_X || phase_q == PH_Y)) begin
      ls = ((HL_W+3)'(tick_q) < (HL_W+3)'(high_ticks_q));
      rs = ((HL_W+3)'(tick_q) >= (HL_W+3)'(hl_sum)) &&
           ((HL_W+3)'(tick_q) < (HL_W+3)'(h2l_sum));
    end
    if (fire && phase_d == PH_IDLE && (phase_q != PH_IDLE || is_move)) begin
      done = 1'b1;
    end
    px_ext = PEW'(pos_x_d);
    py_ext = PEW'(pos_y_d);
    out_data_d = {3'b000, py_ext[POS_Y_W-1:0], px_ext[POS_X_W-1:0], done,
                  (phase_d != PH_IDLE), dir_d[1], dir_d[0], rs, ls};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      pend_x_q <= '0;
      pend_y_q <= '0;
      steps_q  <= '0;
      ysaved_q <= '0;
      tick_q   <= '0;
      dir_q    <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      pend_x_q <= pend_x_d;
      pend_y_q <= pend_y_d;
      steps_q  <= steps_d;
      ysaved_q <= ysaved_d;
      tick_q   <= tick_d;
      dir_q    <= dir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `ASSERT_AT(a_idle_no_steps, (phase_q == PH_IDLE) |-> (steps_q == '0), "idle with steps left")
  `ASSERT_NEVER(a_leg_has_steps, (phase_q == PH_X || phase_q == PH_Y) && steps_q == '0, "empty leg")
  `ASSERT_AT(a_stall_blocks_in, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "lost item")
  `ASSERT_NEVER(a_done_not_busy, m_axis_tvalid && m_axis_tdata[5] && m_axis_tdata[4], "done while busy")

endmodule
